// File: sv/qeou_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qeou_pkg
// Types and constants for the quaternion exponential-map orientation update.
// ----------------------------------------------------------------------------
package qeou_pkg;

  localparam logic [31:0] TS_RESET     = 32'd71582788;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [32:0] HALF_PI_Q32  = 33'd6746518852;
  localparam logic [42:0] ANGLE_THRESH = 43'd429497;
  localparam logic [63:0] RCP_ONE      = 64'd1 << 34;

  // Taylor divisors, lane 0 is the sine series and lane 1 the cosine series.
  localparam logic [7:0] TAY_DIV [2][7] = '{
    '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210},
    '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90,  8'd132, 8'd182}
  };

  localparam logic [33:0] TAY_RCP [2][7] = '{
    '{34'(RCP_ONE / 64'd6),   34'(RCP_ONE / 64'd20),  34'(RCP_ONE / 64'd42),
      34'(RCP_ONE / 64'd72),  34'(RCP_ONE / 64'd110), 34'(RCP_ONE / 64'd156),
      34'(RCP_ONE / 64'd210)},
    '{34'(RCP_ONE / 64'd2),   34'(RCP_ONE / 64'd12),  34'(RCP_ONE / 64'd30),
      34'(RCP_ONE / 64'd56),  34'(RCP_ONE / 64'd90),  34'(RCP_ONE / 64'd132),
      34'(RCP_ONE / 64'd182)}
  };

  // Hamilton product: output o, term a uses e[a] times q[HAM_QIX[o][a]].
  localparam logic [1:0] HAM_QIX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic HAM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  typedef struct packed {
    logic [2:0]            om_neg;
    logic [2:0][31:0]      om_mag;
    logic [3:0][31:0]      q;
    logic [2:0][63:0]      sq;
    logic [63:0]           rn;
    logic [63:0]           rres;
    logic [31:0]           r;
    logic [42:0]           ang;
    logic [1:0]            quad;
    logic                  tiny;
    logic [16:0]           tsm;
    logic [3:0]            t2;
    logic [31:0]           x2;
    logic [1:0][32:0]      tt;
    logic [1:0][63:0]      tp;
    logic [1:0][32:0]      tv;
    logic [1:0][66:0]      tm;
    logic [1:0][35:0]      tacc;
    logic [31:0]           sn;
    logic [31:0]           cs;
    logic [31:0]           coef;
    logic [2:0][61:0]      num;
    logic [2:0][41:0]      smag;
    logic [2:0][31:0]      drem;
    logic [2:0][30:0]      quo;
    logic [3:0][31:0]      e;
    logic [3:0][3:0][63:0] prd;
    logic [3:0][64:0]      acc;
    logic [3:0][31:0]      res;
  } item_t;

endpackage

// File: sv/quaternion_exp_orientation_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_exp_orientation_update
// Rotates a start quaternion by the exponential map of omega times half the
// time step, in a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         omega x/y/z (Q12.20), start w/x/y/z (Q2.30)
//  m_axis    out        new w/x/y/z (Q2.30, saturated)
//  cfg       in         time_step (unsigned Q0.32)
//
//  One item enters per cycle while the output is not stalled. The depth is set
//  by the bit-per-stage square root, the range reduction, the sine and cosine
//  series and the bit-per-stage division of the vector part.
//  Reset clears all valid bits and loads the default time step.
//  A stall at the output freezes every stage together, so nothing is lost.
// ----------------------------------------------------------------------------
module quaternion_exp_orientation_update (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // omega_x, omega_y, omega_z, start_w, start_x, start_y, start_z
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_w, new_x, new_y, new_z
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [31:0]  cfg_data_i
);
  import qeou_pkg::*;

  localparam int ST_CAP = 0;
  localparam int ST_SQR = 1;
  localparam int ST_SUM = 2;
  localparam int ST_RT0 = 3;
  localparam int ST_ANG = 35;
  localparam int ST_RD0 = 36;
  localparam int ST_X   = 47;
  localparam int ST_TY0 = 48;
  localparam int ST_SC  = 69;
  localparam int ST_MUL = 70;
  localparam int ST_DV0 = 71;
  localparam int ST_E   = 102;
  localparam int ST_PRD = 103;
  localparam int ST_ACC = 104;
  localparam int ST_OUT = 105;
  localparam int NSTG   = 106;

  logic [31:0]     ts_q;
  logic [NSTG-1:0] vld_q;
  item_t           pipe_q [NSTG];
  item_t           pipe_d [NSTG];
  logic            adv;

  assign cfg_ready_o   = 1'b1;
  assign adv           = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = pipe_q[NSTG-1].res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q  <= TS_RESET;
      vld_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        ts_q <= cfg_data_i;
      end
      if (adv) begin
        vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pipe_q <= pipe_d;
    end
  end

  always_comb begin
    logic [31:0] w;
    pipe_d[ST_CAP] = '0;
    for (int i = 0; i < 3; i++) begin
      w = s_axis_tdata[32*i +: 32];
      pipe_d[ST_CAP].om_neg[i] = w[31];
      pipe_d[ST_CAP].om_mag[i] = w[31] ? (~w + 32'd1) : w;
    end
    for (int i = 0; i < 4; i++) begin
      pipe_d[ST_CAP].q[i] = s_axis_tdata[96+32*i +: 32];
    end
  end

  always_comb begin
    pipe_d[ST_SQR] = pipe_q[ST_SQR-1];
    for (int i = 0; i < 3; i++) begin
      pipe_d[ST_SQR].sq[i] = {32'd0, pipe_q[ST_SQR-1].om_mag[i]} *
                             {32'd0, pipe_q[ST_SQR-1].om_mag[i]};
    end
  end

  always_comb begin
    pipe_d[ST_SUM]      = pipe_q[ST_SUM-1];
    pipe_d[ST_SUM].rn   = pipe_q[ST_SUM-1].sq[0] + pipe_q[ST_SUM-1].sq[1] +
                          pipe_q[ST_SUM-1].sq[2];
    pipe_d[ST_SUM].rres = '0;
  end

  for (genvar k = 0; k < 32; k++) begin : g_root
    localparam int          IDX = ST_RT0 + k;
    localparam logic [63:0] RB  = 64'd1 << (62 - 2*k);
    always_comb begin
      logic [63:0] trial;
      trial       = pipe_q[IDX-1].rres + RB;
      pipe_d[IDX] = pipe_q[IDX-1];
      if (pipe_q[IDX-1].rn >= trial) begin
        pipe_d[IDX].rn   = pipe_q[IDX-1].rn - trial;
        pipe_d[IDX].rres = (pipe_q[IDX-1].rres >> 1) + RB;
      end else begin
        pipe_d[IDX].rres = pipe_q[IDX-1].rres >> 1;
      end
    end
  end

  always_comb begin
    pipe_d[ST_ANG]      = pipe_q[ST_ANG-1];
    pipe_d[ST_ANG].r    = pipe_q[ST_ANG-1].rres[31:0];
    pipe_d[ST_ANG].ang  = 43'(({32'd0, ts_q} * {32'd0, pipe_q[ST_ANG-1].rres[31:0]}) >> 21);
    pipe_d[ST_ANG].quad = '0;
  end

  for (genvar k = 0; k < 11; k++) begin : g_red
    localparam int          IDX = ST_RD0 + k;
    localparam int          J   = 10 - k;
    localparam logic [43:0] HJ  = {11'd0, HALF_PI_Q32} << J;
    always_comb begin
      logic ge;
      ge          = {1'b0, pipe_q[IDX-1].ang} >= HJ;
      pipe_d[IDX] = pipe_q[IDX-1];
      if (ge) begin
        pipe_d[IDX].ang = 43'({1'b0, pipe_q[IDX-1].ang} - HJ);
      end
      if (J == 1) begin
        pipe_d[IDX].quad[1] = ge;
      end
      if (J == 0) begin
        pipe_d[IDX].quad[0] = ge;
      end
      if (k == 0) begin
        pipe_d[IDX].tiny = pipe_q[IDX-1].ang < ANGLE_THRESH;
        pipe_d[IDX].tsm  = pipe_q[IDX-1].ang[18:2];
      end
    end
  end

  always_comb begin
    logic [30:0] x;
    x                      = pipe_q[ST_X-1].ang[32:2];
    pipe_d[ST_X]           = pipe_q[ST_X-1];
    pipe_d[ST_X].x2        = 32'(({31'd0, x} * {31'd0, x}) >> 30);
    pipe_d[ST_X].tt[0]     = {2'd0, x};
    pipe_d[ST_X].tt[1]     = {2'd0, ONE_Q30};
    pipe_d[ST_X].tacc[0]   = {5'd0, x};
    pipe_d[ST_X].tacc[1]   = {5'd0, ONE_Q30};
    pipe_d[ST_X].t2        = 4'(({17'd0, pipe_q[ST_X-1].tsm} *
                                 {17'd0, pipe_q[ST_X-1].tsm}) >> 30);
  end

  for (genvar k = 0; k < 7; k++) begin : g_tay
    localparam int IA = ST_TY0 + 3*k;
    always_comb begin
      pipe_d[IA] = pipe_q[IA-1];
      for (int l = 0; l < 2; l++) begin
        pipe_d[IA].tp[l] = {31'd0, pipe_q[IA-1].tt[l]} * {32'd0, pipe_q[IA-1].x2};
      end
    end
    always_comb begin
      pipe_d[IA+1] = pipe_q[IA];
      for (int l = 0; l < 2; l++) begin
        pipe_d[IA+1].tv[l] = 33'(pipe_q[IA].tp[l] >> 30);
        pipe_d[IA+1].tm[l] = {34'd0, pipe_d[IA+1].tv[l]} * {33'd0, TAY_RCP[l][k]};
      end
    end
    always_comb begin
      logic [32:0] q0;
      logic [40:0] rem;
      logic [32:0] nt;
      pipe_d[IA+2] = pipe_q[IA+1];
      for (int l = 0; l < 2; l++) begin
        q0  = pipe_q[IA+1].tm[l][66:34];
        rem = {8'd0, pipe_q[IA+1].tv[l]} - {8'd0, q0} * {33'd0, TAY_DIV[l][k]};
        nt  = q0 + 33'(rem >= {33'd0, TAY_DIV[l][k]});
        pipe_d[IA+2].tt[l] = nt;
        if ((k % 2) == 0) begin
          pipe_d[IA+2].tacc[l] = pipe_q[IA+1].tacc[l] - {3'd0, nt};
        end else begin
          pipe_d[IA+2].tacc[l] = pipe_q[IA+1].tacc[l] + {3'd0, nt};
        end
      end
    end
  end

  always_comb begin
    logic [30:0] cl [2];
    logic [30:0] p;
    logic [1:0]  d6;
    for (int l = 0; l < 2; l++) begin
      if ($signed(pipe_q[ST_SC-1].tacc[l]) < 36'sd0) begin
        cl[l] = '0;
      end else if ($signed(pipe_q[ST_SC-1].tacc[l]) > $signed({5'd0, ONE_Q30})) begin
        cl[l] = ONE_Q30;
      end else begin
        cl[l] = pipe_q[ST_SC-1].tacc[l][30:0];
      end
    end
    if (pipe_q[ST_SC-1].t2 >= 4'd12) begin
      d6 = 2'd2;
    end else if (pipe_q[ST_SC-1].t2 >= 4'd6) begin
      d6 = 2'd1;
    end else begin
      d6 = 2'd0;
    end
    p               = ONE_Q30 - {29'd0, d6};
    pipe_d[ST_SC]   = pipe_q[ST_SC-1];
    pipe_d[ST_SC].coef = 32'(({32'd0, ts_q} * {33'd0, p}) >> 31);
    case (pipe_q[ST_SC-1].quad)
      2'd0: begin
        pipe_d[ST_SC].sn = {1'b0, cl[0]};
        pipe_d[ST_SC].cs = {1'b0, cl[1]};
      end
      2'd1: begin
        pipe_d[ST_SC].sn = {1'b0, cl[1]};
        pipe_d[ST_SC].cs = -{1'b0, cl[0]};
      end
      2'd2: begin
        pipe_d[ST_SC].sn = -{1'b0, cl[0]};
        pipe_d[ST_SC].cs = -{1'b0, cl[1]};
      end
      default: begin
        pipe_d[ST_SC].sn = -{1'b0, cl[1]};
        pipe_d[ST_SC].cs = {1'b0, cl[0]};
      end
    endcase
  end

  always_comb begin
    logic [31:0] sabs;
    sabs           = pipe_q[ST_MUL-1].sn[31] ? -pipe_q[ST_MUL-1].sn : pipe_q[ST_MUL-1].sn;
    pipe_d[ST_MUL] = pipe_q[ST_MUL-1];
    for (int i = 0; i < 3; i++) begin
      pipe_d[ST_MUL].num[i]  = {31'd0, sabs[30:0]} * {30'd0, pipe_q[ST_MUL-1].om_mag[i]};
      pipe_d[ST_MUL].smag[i] = 42'(({32'd0, pipe_q[ST_MUL-1].coef} *
                                    {32'd0, pipe_q[ST_MUL-1].om_mag[i]}) >> 22);
    end
    pipe_d[ST_MUL].quo = '0;
  end

  for (genvar k = 0; k < 31; k++) begin : g_div
    localparam int IDX = ST_DV0 + k;
    localparam int J   = 30 - k;
    always_comb begin
      logic [31:0] rin;
      logic [32:0] t;
      logic        ge;
      pipe_d[IDX] = pipe_q[IDX-1];
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          rin = {1'b0, pipe_q[IDX-1].num[i][61:31]};
        end else begin
          rin = pipe_q[IDX-1].drem[i];
        end
        t  = {rin, pipe_q[IDX-1].num[i][J]};
        ge = t >= {1'b0, pipe_q[IDX-1].r};
        pipe_d[IDX].drem[i]   = ge ? 32'(t - {1'b0, pipe_q[IDX-1].r}) : t[31:0];
        pipe_d[IDX].quo[i][J] = ge;
      end
    end
  end

  always_comb begin
    logic [41:0] mag;
    logic        neg;
    logic [31:0] cm;
    pipe_d[ST_E]      = pipe_q[ST_E-1];
    pipe_d[ST_E].e[0] = pipe_q[ST_E-1].cs;
    for (int i = 0; i < 3; i++) begin
      if (pipe_q[ST_E-1].tiny) begin
        mag = pipe_q[ST_E-1].smag[i];
        neg = pipe_q[ST_E-1].om_neg[i];
      end else begin
        mag = {11'd0, pipe_q[ST_E-1].quo[i]};
        neg = pipe_q[ST_E-1].sn[31] != pipe_q[ST_E-1].om_neg[i];
      end
      cm = (mag > {11'd0, ONE_Q30}) ? {1'b0, ONE_Q30} : mag[31:0];
      pipe_d[ST_E].e[i+1] = neg ? -cm : cm;
    end
  end

  always_comb begin
    pipe_d[ST_PRD] = pipe_q[ST_PRD-1];
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        pipe_d[ST_PRD].prd[a][b] =
          {{32{pipe_q[ST_PRD-1].e[a][31]}}, pipe_q[ST_PRD-1].e[a]} *
          {{32{pipe_q[ST_PRD-1].q[b][31]}}, pipe_q[ST_PRD-1].q[b]};
      end
    end
  end

  always_comb begin
    logic [64:0] term;
    pipe_d[ST_ACC] = pipe_q[ST_ACC-1];
    for (int o = 0; o < 4; o++) begin
      pipe_d[ST_ACC].acc[o] = '0;
      for (int a = 0; a < 4; a++) begin
        term = {pipe_q[ST_ACC-1].prd[a][HAM_QIX[o][a]][63],
                pipe_q[ST_ACC-1].prd[a][HAM_QIX[o][a]]};
        if (HAM_NEG[o][a]) begin
          pipe_d[ST_ACC].acc[o] = pipe_d[ST_ACC].acc[o] - term;
        end else begin
          pipe_d[ST_ACC].acc[o] = pipe_d[ST_ACC].acc[o] + term;
        end
      end
    end
  end

  always_comb begin
    logic signed [34:0] sh;
    pipe_d[ST_OUT] = pipe_q[ST_OUT-1];
    for (int o = 0; o < 4; o++) begin
      sh = 35'($signed(pipe_q[ST_OUT-1].acc[o]) >>> 30);
      if (sh > 35'sd2147483647) begin
        pipe_d[ST_OUT].res[o] = 32'h7FFF_FFFF;
      end else if (sh < -35'sd2147483648) begin
        pipe_d[ST_OUT].res[o] = 32'h8000_0000;
      end else begin
        pipe_d[ST_OUT].res[o] = sh[31:0];
      end
    end
  end

  a_root_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_ANG-1] |-> pipe_q[ST_ANG-1].rres[63:32] == 32'd0)
    else $error("Square root result exceeds 32 bits.");

  a_small_quad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_X] && pipe_q[ST_X].tiny |-> pipe_q[ST_X].quad == 2'd0)
    else $error("Small angle left the first quadrant.");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_E-1] && pipe_q[ST_E-1].r != 32'd0 |->
      pipe_q[ST_E-1].drem[0] < pipe_q[ST_E-1].r &&
      pipe_q[ST_E-1].drem[1] < pipe_q[ST_E-1].r &&
      pipe_q[ST_E-1].drem[2] < pipe_q[ST_E-1].r)
    else $error("Division remainder not below the divisor.");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion exponential-map orientation update.
// A table of directed transfers is followed by random transfers under several
// time steps and stall patterns. Results match a table entry or a predictor.
// ----------------------------------------------------------------------------
module tb;
  import qeou_pkg::*;

  localparam int unsigned LATENCY   = 106;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam int unsigned RAND_ITEMS = 1100;

  typedef struct {
    logic [31:0] om [3];
    logic [31:0] q  [4];
    bit          known;
    logic [31:0] res [4];
  } row_t;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [223:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i, cfg_ready_o;
  logic [31:0]  cfg_data_i;

  logic [31:0]  step_shadow;
  logic [127:0] quat_due [$];
  bit           s_took, cfg_took, row_known;
  logic [127:0] row_res;
  int unsigned  fails, quiet_cycles;
  int unsigned  send_idle, recv_idle;
  row_t         rows [$];

  quaternion_exp_orientation_update DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] t;
    t = 65'(a) + 65'(b);
    if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(t);
  endfunction

  function automatic logic [31:0] q30_out(longint a);
    longint v;
    v = a >>> 30;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [127:0] rotate_quat(logic [31:0] ts, logic [223:0] d);
    longint om [3], q [4], e [4];
    longint unsigned mg [3];
    longint unsigned r2, n, r, bt, ang, half, quad, x, x2, tsn, tcn;
    longint unsigned t, t2, t4, p, coef, m;
    longint sn, cs, s, c;
    r2 = 0;
    for (int i = 0; i < 3; i++) begin
      om[i] = longint'(signed'(d[32*i +: 32]));
      mg[i] = (om[i] < 0) ? longint'(-om[i]) : om[i];
      r2 += mg[i] * mg[i];
    end
    for (int i = 0; i < 4; i++) q[i] = longint'(signed'(d[96 + 32*i +: 32]));
    n = r2; r = 0; bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    ang  = (64'(ts) * r) >> 21;
    half = 64'(HALF_PI_Q32);
    quad = (ang / half) & 3;
    x    = (ang % half) >> 2;
    x2   = (x * x) >> 30;
    tsn = x; tcn = 64'd1 << 30; sn = x; cs = 64'sd1 << 30;
    for (int k = 1; k <= 7; k++) begin
      tsn = ((tsn * x2) >> 30) / 64'((2*k) * (2*k + 1));
      tcn = ((tcn * x2) >> 30) / 64'((2*k - 1) * (2*k));
      if (k % 2 == 1) begin
        sn -= tsn; cs -= tcn;
      end else begin
        sn += tsn; cs += tcn;
      end
    end
    if (sn < 0) sn = 0;
    if (sn > (64'sd1 << 30)) sn = 64'sd1 << 30;
    if (cs < 0) cs = 0;
    if (cs > (64'sd1 << 30)) cs = 64'sd1 << 30;
    case (quad)
      0: begin s = sn;  c = cs;  end
      1: begin s = cs;  c = -sn; end
      2: begin s = -sn; c = -cs; end
      default: begin s = -cs; c = sn; end
    endcase
    e[0] = c;
    if (ang < 64'(ANGLE_THRESH)) begin
      t    = ang >> 2;
      t2   = (t * t) >> 30;
      t4   = (t2 * t2) >> 30;
      p    = (64'd1 << 30) - t2 / 6 + t4 / 120;
      coef = (64'(ts) * p) >> 31;
      for (int i = 0; i < 3; i++) begin
        m = (coef * mg[i]) >> 22;
        e[1+i] = (om[i] < 0) ? -longint'(m) : longint'(m);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        m = (r != 0) ? ((s < 0 ? -s : s) * mg[i]) / r : 0;
        e[1+i] = ((s < 0) != (om[i] < 0)) ? -longint'(m) : longint'(m);
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (e[i] > (64'sd1 << 30)) e[i] = 64'sd1 << 30;
      if (e[i] < -(64'sd1 << 30)) e[i] = -(64'sd1 << 30);
    end
    return {
      q30_out(sat_sum(sat_sum(sat_sum(e[0]*q[3], e[1]*q[2]), -e[2]*q[1]), e[3]*q[0])),
      q30_out(sat_sum(sat_sum(sat_sum(e[0]*q[2], -e[1]*q[3]), e[2]*q[0]), e[3]*q[1])),
      q30_out(sat_sum(sat_sum(sat_sum(e[0]*q[1], e[1]*q[0]), e[2]*q[3]), -e[3]*q[2])),
      q30_out(sat_sum(sat_sum(sat_sum(e[0]*q[0], -e[1]*q[1]), -e[2]*q[2]), -e[3]*q[3]))
    };
  endfunction

  // Transfer monitor: predicts on input transfers and checks output transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want;
    if (!rst_ni) begin
      step_shadow = TS_RESET;
      s_took = 1'b0;
      cfg_took = 1'b0;
    end else begin
      s_took = s_axis_tvalid && s_axis_tready;
      cfg_took = cfg_valid_i && cfg_ready_o;
      if (cfg_took) step_shadow = cfg_data_i;
      if (s_took)
        quat_due.push_back(row_known ? row_res : rotate_quat(step_shadow, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (quat_due.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
          fails++;
        end else begin
          want = quat_due.pop_front();
          for (int f = 0; f < 4; f++)
            if (want[32*f +: 32] !== m_axis_tdata[32*f +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want[32*f +: 32], m_axis_tdata[32*f +: 32]);
              fails++;
            end
        end
      end
      if (s_took || cfg_took || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_quat(logic [223:0] d, bit known, logic [127:0] res);
    s_axis_tdata  <= d;
    row_known     <= known;
    row_res       <= res;
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (!s_took);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
  endtask

  task automatic drain_then_write(logic [31:0] ts);
    s_axis_tvalid <= 1'b0;
    while (quat_due.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    cfg_data_i  <= ts;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_took);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_omega(int kind);
    case (kind)
      0: return 32'($signed($urandom_range(8191)) - 4096);
      1: return 32'($signed($urandom_range(32'h0FFF_FFFF)) - 32'sh0800_0000);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    row_t rw;
    logic [223:0] d;
    logic [31:0] steps [6];
    int kind;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    row_known = 1'b0;
    row_res = '0;
    fails = 0;
    quiet_cycles = 0;
    send_idle = 30;
    recv_idle = 84;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero omega leaves the start quaternion unchanged, even at the extremes.
    rw.om = '{0, 0, 0}; rw.known = 1;
    rw.q = '{32'h4000_0000, 0, 0, 0}; rw.res = rw.q; rows.push_back(rw);
    rw.q = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    rw.res = rw.q; rows.push_back(rw);
    rw.q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};
    rw.res = rw.q; rows.push_back(rw);
    rw.known = 0;
    rw.q = '{32'h4000_0000, 0, 0, 0};
    rw.om = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; rows.push_back(rw);
    rw.om = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; rows.push_back(rw);
    rw.om = '{32'h8000_0000, 0, 0}; rows.push_back(rw);
    rw.om = '{0, 32'h7FFF_FFFF, 0}; rows.push_back(rw);
    rw.om = '{0, 0, 32'h0010_0000}; rows.push_back(rw);
    rw.om = '{1, 0, 0}; rows.push_back(rw);
    rw.om = '{32'hFFFF_FFFF, 1, 32'hFFFF_FFFF}; rows.push_back(rw);
    rw.om = '{0, 0, 32'd48000}; rows.push_back(rw);
    rw.om = '{0, 0, 32'd52000}; rows.push_back(rw);
    rw.om = '{32'h0640_0000, 32'hF9C0_0000, 32'h0320_0000}; rows.push_back(rw);
    rw.q = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    rows.push_back(rw);
    rw.q = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    rows.push_back(rw);
    rw.om = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}; rows.push_back(rw);

    foreach (rows[i])
      send_quat({rows[i].q[3], rows[i].q[2], rows[i].q[1], rows[i].q[0],
                 rows[i].om[2], rows[i].om[1], rows[i].om[0]}, rows[i].known,
                {rows[i].res[3], rows[i].res[2], rows[i].res[1], rows[i].res[0]});

    steps = '{TS_RESET, 32'd0, 32'hFFFF_FFFF, $urandom(), 32'd1, 32'h0100_0000};
    for (int ph = 0; ph < 6; ph++) begin
      drain_then_write(steps[ph]);
      case (ph % 3)
        0: begin send_idle = 30; recv_idle = 84; end
        1: begin send_idle = 84; recv_idle = 30; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int n = 0; n < RAND_ITEMS / 6; n++) begin
        kind = $urandom_range(2);
        for (int i = 0; i < 3; i++) d[32*i +: 32] = rand_omega(kind);
        if ($urandom_range(1)) begin
          for (int i = 3; i < 7; i++)
            d[32*i +: 32] = 32'($signed($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
        end else begin
          for (int i = 3; i < 7; i++) d[32*i +: 32] = $urandom();
        end
        send_quat(d, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (quat_due.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
sv/qeou_pkg.sv
sv/quaternion_exp_orientation_update.sv
tb/tb.sv
